/* rtl/core/hex_color_parse_premultiply_assert.svh */
// assertion macros for the hex colour parser
`ifndef HEX_COLOR_PARSE_PREMULTIPLY_ASSERT_SVH
`define HEX_COLOR_PARSE_PREMULTIPLY_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HCP_ASSERT_SAME(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("hcp assertion failed");
`define HCP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("hcp assertion failed");
`else
`define HCP_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define HCP_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

/* rtl/core/hcp_pkg.sv */
// shared types, character codes and helper functions for the hex colour parser
package hcp_pkg;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;

  localparam logic [3:0] COUNT_SAT = 4'd10;
  localparam logic [3:0] LEN_RGB   = 4'd3;
  localparam logic [3:0] LEN_RGBA  = 4'd4;
  localparam logic [3:0] LEN_RRGGBB   = 4'd6;
  localparam logic [3:0] LEN_RRGGBBAA = 4'd8;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } hcp_color_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hcp_digit_t;

  function automatic hcp_digit_t hex_digit(input logic [7:0] c);
    hcp_digit_t d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    case (c) inside
      [CH_0:CH_9]: begin
        diff = c - CH_0;
        d.valid = 1'b1;
        d.value = diff[3:0];
      end
      [CH_LA:CH_LF]: begin
        diff = c - CH_LA + 8'd10;
        d.valid = 1'b1;
        d.value = diff[3:0];
      end
      [CH_UA:CH_UF]: begin
        diff = c - CH_UA + 8'd10;
        d.valid = 1'b1;
        d.value = diff[3:0];
      end
      default: begin
        d = '0;
      end
    endcase
    return d;
  endfunction

  // round(c*a/255), exact for 8-bit operands
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] t;
    logic [16:0] s;
    p = 16'(c) * 16'(a);
    t = {1'b0, p} + 17'd128;
    s = t + (t >> 8);
    return s[15:8];
  endfunction

endpackage

/* rtl/core/hcp_parse.sv */
// character counter, hex accumulator and length decode for one colour text
module hcp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         ch,
  input  logic               is_last,
  output hcp_pkg::hcp_color_t color
);
  import hcp_pkg::*;

  logic [3:0]  count_r, count_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic        bad_r, bad_nxt;
  hcp_digit_t  digit;
  hcp_color_t  dec;

  always_comb begin
    digit     = hex_digit(ch);
    bad_nxt   = bad_r;
    accum_nxt = accum_r;
    if (count_r == 4'd0) begin
      if (ch != CH_HASH) begin
        bad_nxt = 1'b1;
      end
    end else if (!digit.valid) begin
      bad_nxt = 1'b1;
    end else begin
      accum_nxt = {accum_r[27:0], digit.value};
    end
    count_nxt = (count_r >= COUNT_SAT) ? COUNT_SAT : count_r + 4'd1;
  end

  // expand by length; short forms repeat each nibble
  always_comb begin
    dec       = '0;
    dec.ok    = !bad_nxt;
    dec.alpha = ALPHA_OPAQUE;
    case (count_r)
      LEN_RGB: begin
        dec.red   = {2{accum_nxt[11:8]}};
        dec.green = {2{accum_nxt[7:4]}};
        dec.blue  = {2{accum_nxt[3:0]}};
      end
      LEN_RGBA: begin
        dec.red   = {2{accum_nxt[15:12]}};
        dec.green = {2{accum_nxt[11:8]}};
        dec.blue  = {2{accum_nxt[7:4]}};
        dec.alpha = {2{accum_nxt[3:0]}};
      end
      LEN_RRGGBB: begin
        dec.red   = accum_nxt[23:16];
        dec.green = accum_nxt[15:8];
        dec.blue  = accum_nxt[7:0];
      end
      LEN_RRGGBBAA: begin
        dec.red   = accum_nxt[31:24];
        dec.green = accum_nxt[23:16];
        dec.blue  = accum_nxt[15:8];
        dec.alpha = accum_nxt[7:0];
      end
      default: begin
        dec.ok = 1'b0;
      end
    endcase
    color = dec.ok ? dec : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      accum_r <= '0;
      bad_r   <= 1'b0;
    end else if (step) begin
      if (is_last) begin
        count_r <= '0;
        accum_r <= '0;
        bad_r   <= 1'b0;
      end else begin
        count_r <= count_nxt;
        accum_r <= accum_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

endmodule

/* rtl/core/hex_color_parse_premultiply.sv */
// top level: hex colour text parser with premultiplied alpha result
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   ch[7:0], is_last
//   out_     output     out_valid/out_stall ok, red, green, blue, alpha [7:0]
//
// one character per cycle is taken while in_stall is low, whatever the text length
// after its final character is taken, a result is registered in the decode stage and then in the output stage
// stages: input register, parse and decode register, premultiply output register
// reset clears the character count, accumulator, error flag and all valids
// a stalled result holds; earlier stages keep filling behind it
module hex_color_parse_premultiply (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  import hcp_pkg::*;

  `include "hex_color_parse_premultiply_assert.svh"

  logic       a_valid_r;
  logic [7:0] a_ch_r;
  logic       a_last_r;
  logic       b_valid_r;
  hcp_color_t b_color_r;
  hcp_color_t dec_color;
  logic       out_valid_r;
  hcp_color_t out_color_r;

  logic c_move, b_free, a_move, a_fire, in_xfer, b_fire;

  assign c_move  = !out_valid_r || !out_stall;
  assign b_free  = !b_valid_r || c_move;
  assign a_move  = !a_last_r || b_free;
  assign a_fire  = a_valid_r && a_move;
  assign in_stall = a_valid_r && !a_move;
  assign in_xfer = in_valid && !in_stall;
  assign b_fire  = b_valid_r && c_move;

  hcp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (a_fire),
    .ch      (a_ch_r),
    .is_last (a_last_r),
    .color   (dec_color)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        a_valid_r <= 1'b1;
      end else if (a_fire) begin
        a_valid_r <= 1'b0;
      end
      if (a_fire && a_last_r) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
      if (b_fire) begin
        out_valid_r <= 1'b1;
      end else if (c_move) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_ch_r   <= in_ch;
      a_last_r <= in_is_last;
    end
    if (a_fire && a_last_r) begin
      b_color_r <= dec_color;
    end
    if (b_fire) begin
      out_color_r.ok    <= b_color_r.ok;
      out_color_r.red   <= premul(b_color_r.red, b_color_r.alpha);
      out_color_r.green <= premul(b_color_r.green, b_color_r.alpha);
      out_color_r.blue  <= premul(b_color_r.blue, b_color_r.alpha);
      out_color_r.alpha <= b_color_r.alpha;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_color_r.ok;
  assign out_red   = out_color_r.red;
  assign out_green = out_color_r.green;
  assign out_blue  = out_color_r.blue;
  assign out_alpha = out_color_r.alpha;

  // only a final character waiting on a full decode stage holds the input
  `HCP_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, a_valid_r && a_last_r && b_valid_r)
  `HCP_ASSERT_SAME(a_bad_zero, clk, rst_n, out_valid && !out_ok,
    (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0) && (out_alpha == 8'd0))
  `HCP_ASSERT_SAME(a_premul_bound, clk, rst_n, out_valid && out_ok,
    (out_red <= out_alpha) && (out_green <= out_alpha) && (out_blue <= out_alpha))
  `HCP_ASSERT_NEXT(a_decode_to_out, clk, rst_n, b_valid_r && c_move, out_valid)

endmodule

/* bench/tb.sv */
// testbench for the hex colour parser: directed texts and a randomised character stream checked against a predictor
`timescale 1ns / 100ps

module tb;
  import hcp_pkg::*;

  typedef logic [7:0] char_q_t[$];

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  localparam int IDLE_LIMIT  = 2000;
  localparam int TEXT_ITEMS  = 1250;
  localparam int DRAIN_SLACK = 12;

  class color_scoreboard;
    hcp_color_t  expected_colors[$];
    logic [3:0]  char_count;
    logic [31:0] hex_accum;
    bit          bad_flag;
    int          errors;

    function new();
      char_count = '0;
      hex_accum  = '0;
      bad_flag   = 1'b0;
      errors     = 0;
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      return -1;
    endfunction

    function logic [7:0] scale_by_alpha(int unsigned c, int unsigned a);
      int unsigned prod;
      prod = (c * a + 127) / 255;
      return prod[7:0];
    endfunction

    function void note_char(logic [7:0] c, logic last);
      logic [3:0]  pos;
      int          v;
      int unsigned r, g, b, a;
      bit          ok;
      hcp_color_t  exp_color;
      pos = char_count;
      if (pos == 4'd0) begin
        if (c != CH_HASH) bad_flag = 1'b1;
      end else begin
        v = nibble_of(c);
        if (v < 0) bad_flag = 1'b1;
        else hex_accum = {hex_accum[27:0], v[3:0]};
      end
      char_count = (pos >= COUNT_SAT) ? COUNT_SAT : pos + 4'd1;
      if (!last) return;
      ok = !bad_flag;
      r = 0;
      g = 0;
      b = 0;
      a = ALPHA_OPAQUE;
      case (pos)
        LEN_RGB: begin
          r = hex_accum[11:8] * 17;
          g = hex_accum[7:4] * 17;
          b = hex_accum[3:0] * 17;
        end
        LEN_RGBA: begin
          r = hex_accum[15:12] * 17;
          g = hex_accum[11:8] * 17;
          b = hex_accum[7:4] * 17;
          a = hex_accum[3:0] * 17;
        end
        LEN_RRGGBB: begin
          r = hex_accum[23:16];
          g = hex_accum[15:8];
          b = hex_accum[7:0];
        end
        LEN_RRGGBBAA: begin
          r = hex_accum[31:24];
          g = hex_accum[23:16];
          b = hex_accum[15:8];
          a = hex_accum[7:0];
        end
        default: begin
          ok = 1'b0;
        end
      endcase
      exp_color = '0;
      if (ok) begin
        exp_color.ok    = 1'b1;
        exp_color.red   = scale_by_alpha(r, a);
        exp_color.green = scale_by_alpha(g, a);
        exp_color.blue  = scale_by_alpha(b, a);
        exp_color.alpha = a[7:0];
      end
      expected_colors.push_back(exp_color);
      char_count = '0;
      hex_accum  = '0;
      bad_flag   = 1'b0;
    endfunction

    function void check_color(hcp_color_t got);
      hcp_color_t want;
      if (expected_colors.size() == 0) begin
        $error("result transfer with nothing pending: ok %0d red %0d green %0d blue %0d alpha %0d",
               got.ok, got.red, got.green, got.blue, got.alpha);
        errors++;
        return;
      end
      want = expected_colors.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok mismatch: expected %0d, got %0d", want.ok, got.ok);
        errors++;
      end
      if (got.red !== want.red) begin
        $error("red mismatch: expected %0d, got %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green mismatch: expected %0d, got %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue mismatch: expected %0d, got %0d", want.blue, got.blue);
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("alpha mismatch: expected %0d, got %0d", want.alpha, got.alpha);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch      = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic       out_ok;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  color_scoreboard sb = new();
  int              burst_left = 0;
  int              chars_sent = 0;
  int              idle_cycles = 0;
  stall_mode_t     stall_mode = STALL_NONE;
  int              stall_left = 0;
  bit              toggle_bit = 1'b0;

  hex_color_parse_premultiply dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .in_is_last (in_is_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_ok     (out_ok),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(5, 80);
      end
      stall_left--;
      toggle_bit = ~toggle_bit;
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        STALL_TOGGLE: out_stall <= toggle_bit;
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    hcp_color_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_ok, out_red, out_green, out_blue, out_alpha};
        sb.check_color(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic char_q_t from_string(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_0 + 8'(v);
    if ($urandom_range(0, 1) == 0) return CH_LA + 8'(v - 10);
    return CH_UA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] random_bad_char();
    logic [7:0] specials[14] = '{8'h20, 8'h09, 8'h2b, 8'h2d, 8'h78, 8'h58, 8'h00, 8'h2f,
                                 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67, 8'h23};
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return specials[$urandom_range(0, 13)];
    do c = 8'($urandom_range(0, 255)); while (
      (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF));
    return c;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_ch      <= c;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  task automatic push_text(input char_q_t text);
    foreach (text[i]) push_char(text[i], i == text.size() - 1);
  endtask

  task automatic push_random_text();
    char_q_t text;
    int      kind;
    int      len;
    int      lens[4] = '{3, 4, 6, 8};
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      len = lens[$urandom_range(0, 3)];
      text.push_back(CH_HASH);
      repeat (len) text.push_back(random_hex_char());
      if (kind == 7) text[$urandom_range(0, len)] = random_bad_char();
    end else if (kind == 8) begin
      len = $urandom_range(0, 13);
      text.push_back(CH_HASH);
      repeat (len) text.push_back(random_hex_char());
    end else begin
      len = $urandom_range(1, 14);
      repeat (len) text.push_back(8'($urandom_range(0, 255)));
    end
    push_text(text);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_text(from_string("#"));
    push_text(from_string("#9aF"));
    push_text(from_string("#Ab0c"));
    push_text(from_string("#ff000080"));
    push_text(from_string("#123456"));
    push_text('{8'h00});
    push_text('{CH_HASH, 8'hff});

    while (chars_sent < TEXT_ITEMS) push_random_text();

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/hcp_pkg.sv
rtl/core/hcp_parse.sv
rtl/core/hex_color_parse_premultiply.sv
bench/tb.sv
